// ===== rtl/core/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg: selection count package
// Field widths and default limits shared by the selection counter.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int POOL_W  = 16;
    localparam int SEL_W   = 7;
    localparam int COUNT_W = 40;

    localparam logic [7:0]       SCS_MAX_PER_VIDEO = 8'd64;
    localparam longint unsigned  SCS_COUNT_CEILING = 64'd1000000000000;

endpackage

// ===== rtl/core/selection_count_saturating_unit.sv =====
// ----------------------------------------------------------------------------
// selection_count_saturating_unit: saturating selection counter
// Counts n^k, P(n,k), C(n,k) or C(n+k-1,k), with mandatory items and k!,
// on one shift-add multiplier and one restoring divider under a sequencer.
// Each power, permutation or factorial step is one multiply; each binomial
// step is a multiply followed by a divide. At the default 10^12 ceiling,
// MB_W = VAL_W = 40.
// One request at a time; the next beat can be taken in the same cycle that the result appears.
// Reset: asynchronous, active low; the sequencer returns to idle, no beat out.
// ----------------------------------------------------------------------------
module selection_count_saturating_unit #(
    parameter longint unsigned COUNT_CEILING = scs_pkg::SCS_COUNT_CEILING
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [scs_pkg::POOL_W-1:0]  pool_size,
    input  logic [scs_pkg::SEL_W-1:0]   per_video,
    input  logic [scs_pkg::SEL_W-1:0]   mandatory_count,
    input  logic                        ordered,
    input  logic                        allow_repeats,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [scs_pkg::COUNT_W-1:0] count,
    output logic                        overflow
);
    import scs_pkg::*;

    localparam int VAL_W = $clog2(COUNT_CEILING + 64'd1);
    localparam int OPD_W = 17;
    localparam int MB_W  = (VAL_W > OPD_W) ? VAL_W : OPD_W;
    localparam int ACC_W = VAL_W + 2;
    localparam int CNT_W = $clog2(MB_W + 1);
    localparam logic [ACC_W-1:0] CEIL = ACC_W'(COUNT_CEILING);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_ITER, S_MUL, S_DIV, S_DONE} state_t;
    typedef enum logic [2:0] {PH_POW, PH_PERM, PH_COMB, PH_FACT, PH_FINAL} phase_t;

    state_t              state_reg, state_next;
    phase_t              ph_reg, ph_next;
    logic [POOL_W-1:0]   n_reg, n_next;
    logic [SEL_W-1:0]    k_reg, k_next;
    logic [SEL_W-1:0]    m_reg, m_next;
    logic                ord_reg, ord_next;
    logic                rep_reg, rep_next;
    logic [VAL_W-1:0]    t_reg, t_next;
    logic [VAL_W-1:0]    f_reg, f_next;
    logic [7:0]          idx_reg, idx_next;
    logic [7:0]          lim_reg, lim_next;
    logic [OPD_W-1:0]    base_reg, base_next;
    logic                ovf_reg, ovf_next;
    logic [VAL_W-1:0]    ma_reg, ma_next;
    logic [MB_W-1:0]     mb_reg, mb_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          rem_reg, rem_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                overflow_reg, overflow_next;

    logic                invalid;
    logic [SEL_W-1:0]    need;
    logic [OPD_W-1:0]    comb_n;
    logic [OPD_W-1:0]    half;
    logic [7:0]          kk;
    logic [OPD_W-1:0]    opnd;
    logic [ACC_W:0]      acc_sh;
    logic [ACC_W-1:0]    acc_step;
    logic [MB_W:0]       mb_sh;
    logic [8:0]          rem_sh;
    logic                div_ge;
    logic [8:0]          rem_sub;
    logic [VAL_W:0]      t_sh;
    logic [COUNT_W+VAL_W-1:0] count_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign overflow  = overflow_reg;

    always_comb
    begin
        invalid = (k_reg == '0) || (n_reg == '0) || ({1'b0, k_reg} > SCS_MAX_PER_VIDEO)
                  || (m_reg > k_reg) || (!rep_reg && (POOL_W'(k_reg) > n_reg));
        need    = k_reg - m_reg;
        if (rep_reg)
            comb_n = {1'b0, n_reg} + OPD_W'(need) - OPD_W'(1);
        else
            comb_n = {1'b0, n_reg} - OPD_W'(m_reg);
        half = comb_n - OPD_W'(need);
        kk   = (OPD_W'(need) > half) ? 8'(half) : 8'(need);

        case (ph_reg)
            PH_POW:  opnd = {1'b0, n_reg};
            PH_PERM: opnd = {1'b0, n_reg} - OPD_W'(idx_reg) + OPD_W'(1);
            PH_COMB: opnd = base_reg + OPD_W'(idx_reg);
            PH_FACT: opnd = OPD_W'(idx_reg);
            default: opnd = '0;
        endcase

        acc_sh   = {acc_reg, 1'b0};
        acc_step = acc_sh[ACC_W-1:0] + (mb_reg[MB_W-1] ? ACC_W'(ma_reg) : '0);
        mb_sh    = {mb_reg, 1'b0};

        rem_sh  = {rem_reg, t_reg[VAL_W-1]};
        div_ge  = (rem_sh >= {1'b0, idx_reg});
        rem_sub = rem_sh - {1'b0, idx_reg};
        t_sh    = {t_reg, div_ge};

        count_ext = {{COUNT_W{1'b0}}, t_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        ord_next       = ord_reg;
        rep_next       = rep_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        base_next      = base_reg;
        ovf_next       = ovf_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = pool_size;
                    k_next     = per_video;
                    m_next     = mandatory_count;
                    ord_next   = ordered;
                    rep_next   = allow_repeats;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                ovf_next = 1'b0;
                t_next   = VAL_W'(1);
                idx_next = 8'd1;
                if (invalid)
                begin
                    t_next     = '0;
                    state_next = S_DONE;
                end
                else if ((m_reg == '0) && ord_reg)
                begin
                    ph_next    = rep_reg ? PH_POW : PH_PERM;
                    lim_next   = 8'(k_reg);
                    state_next = S_ITER;
                end
                else
                begin
                    ph_next    = PH_COMB;
                    lim_next   = kk;
                    base_next  = comb_n - OPD_W'(kk);
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                if (ovf_reg)
                    state_next = S_DONE;
                else if (idx_reg > lim_reg)
                begin
                    if ((ph_reg == PH_COMB) && (m_reg != '0) && ord_reg)
                    begin
                        ph_next  = PH_FACT;
                        f_next   = VAL_W'(1);
                        idx_next = 8'd1;
                        lim_next = 8'(k_reg);
                    end
                    else if (ph_reg == PH_FACT)
                    begin
                        ph_next  = PH_FINAL;
                        idx_next = 8'd1;
                        lim_next = 8'd1;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    ma_next    = (ph_reg == PH_FACT) ? f_reg : t_reg;
                    mb_next    = (ph_reg == PH_FINAL) ? MB_W'(f_reg) : MB_W'(opnd);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(MB_W);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = acc_step;
                mb_next  = mb_sh[MB_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (acc_step > CEIL)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_ITER;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    if (ph_reg == PH_FACT)
                        f_next = acc_step[VAL_W-1:0];
                    else
                        t_next = acc_step[VAL_W-1:0];
                    if (ph_reg == PH_COMB)
                    begin
                        rem_next   = '0;
                        cnt_next   = CNT_W'(VAL_W);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 8'd1;
                        state_next = S_ITER;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = div_ge ? rem_sub[7:0] : rem_sh[7:0];
                t_next   = t_sh[VAL_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    idx_next   = idx_reg + 8'd1;
                    state_next = S_ITER;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = ovf_reg ? '0 : count_ext[COUNT_W-1:0];
                    overflow_next  = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_POW;
            n_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            ord_reg       <= 1'b0;
            rep_reg       <= 1'b0;
            t_reg         <= '0;
            f_reg         <= '0;
            idx_reg       <= '0;
            lim_reg       <= '0;
            base_reg      <= '0;
            ovf_reg       <= 1'b0;
            ma_reg        <= '0;
            mb_reg        <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            ord_reg       <= ord_next;
            rep_reg       <= rep_next;
            t_reg         <= t_next;
            f_reg         <= f_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            base_reg      <= base_next;
            ovf_reg       <= ovf_next;
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
        end
    end

endmodule
